### design/bbc_pkg.sv
`default_nettype none

package bbc_pkg;

  // Field widths fixed by the interface.
  localparam int PIXEL_W     = 8;
  localparam int SIZE_W      = 11;
  localparam int CFG_INDEX_W = 2;
  localparam int ROW_OUT_W   = 10;
  localparam int COL_OUT_W   = 10;
  localparam int COUNT_OUT_W = 21;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  // Values after reset.
  localparam logic [PIXEL_W-1:0] THRESHOLD_RESET = 8'd200;
  localparam logic [SIZE_W-1:0]  WIDTH_RESET     = 11'd640;
  localparam logic [SIZE_W-1:0]  HEIGHT_RESET    = 11'd480;

  // Depth of the queue between front and back (a power of two).
  localparam int QUEUE_DEPTH = 4;

  // One classified pixel on its way from the front to the back.
  typedef struct packed {
    logic lit;
    logic first;
    logic row_end;
    logic frame_end;
  } pix_item_t;

endpackage

`default_nettype wire

### design/bbc_ram.sv
`default_nettype none

module bbc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/bbc_fifo.sv
`default_nettype none

module bbc_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire bbc_pkg::pix_item_t push_item,
  input  wire logic              pop,
  output bbc_pkg::pix_item_t     pop_item,
  output logic                   full,
  output logic                   empty
);

  localparam int PW = $clog2(bbc_pkg::QUEUE_DEPTH);
  localparam int NW = $clog2(bbc_pkg::QUEUE_DEPTH + 1);

  bbc_pkg::pix_item_t slots [bbc_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;

  assign full     = (count == NW'(bbc_pkg::QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_item = slots[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + NW'(push) - NW'(pop);
    end
  end

  // Item storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

### design/bbc_front.sv
`default_nettype none

module bbc_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 restart,
  input  wire logic [bbc_pkg::PIXEL_W-1:0]          threshold,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0]       width_eff,
  input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]      height_eff,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [bbc_pkg::PIXEL_W-1:0]          pixel,
  input  wire logic                                 queue_full,
  output logic                                      push,
  output bbc_pkg::pix_item_t                        push_item
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic          row_end;
  logic          frame_end;

  assign in_ready  = !queue_full;
  assign push      = in_valid && !queue_full;
  assign row_end   = ((WW'(col) + WW'(1)) == width_eff);
  assign frame_end = row_end && ((HW'(row) + HW'(1)) == height_eff);

  // Classify the pixel and mark where it sits in the frame.
  always_comb begin
    push_item.lit       = (pixel >= threshold);
    push_item.first     = (row == '0) && (col == '0);
    push_item.row_end   = row_end;
    push_item.frame_end = frame_end;
  end

  // Raster position of the next pixel.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (push) begin
      if (row_end) begin
        col <= '0;
        row <= frame_end ? '0 : row + RW'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### design/bbc_div.sv
`default_nettype none

module bbc_div #(
  parameter int NUM_W = 30,
  parameter int DEN_W = 21
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic      [NUM_W-1:0] quot
);

  localparam int KW = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [KW-1:0]    steps;
  logic             busy;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             take;

  // One restoring step: bring down the next dividend bit and try the subtract.
  always_comb begin
    shifted = {rem, quot[NUM_W-1]};
    diff    = shifted - {1'b0, den};
    take    = (shifted >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem   <= '0;
        quot  <= num;
        steps <= KW'(NUM_W);
        busy  <= 1'b1;
      end else if (busy) begin
        rem   <= take ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        quot  <= {quot[NUM_W-2:0], take};
        steps <= steps - KW'(1);
        if (steps == KW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### design/bbc_back.sv
`default_nettype none

module bbc_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0]       width_eff,
  input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]      height_eff,
  input  wire logic                                 queue_empty,
  output logic                                      pop,
  input  wire bbc_pkg::pix_item_t                   pop_item,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [bbc_pkg::ROW_OUT_W-1:0]             row_centroid,
  output logic [bbc_pkg::COL_OUT_W-1:0]             column_centroid,
  output logic [bbc_pkg::COUNT_OUT_W-1:0]           lit_pixel_count
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int VCW  = $clog2(MAX_WIDTH + 2);
  localparam int VRW  = $clog2(MAX_HEIGHT + 2);
  localparam int FAW  = RW + CW;
  localparam int FRAME_DEPTH = MAX_HEIGHT * (2 ** CW);
  localparam int LB_DEPTH    = MAX_WIDTH + 2;
  localparam int NW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 2);
  localparam int SW   = $clog2(MAX_WIDTH * MAX_HEIGHT) +
                        $clog2((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT);

  typedef enum logic [3:0] {
    B_LOAD, B_PREP, B_SCAN, B_DRAIN, B_ROW_GO, B_ROW_DIV, B_COL_GO, B_COL_DIV, B_HOLD
  } back_state_t;

  back_state_t state;

  // Load side.
  logic [RW-1:0]  wrow;
  logic [CW-1:0]  wcol;
  logic [RW-1:0]  lrow;
  logic [CW-1:0]  lcol;

  // Pass control and scan position (two columns and rows of padding).
  logic [1:0]     pass;
  logic           erode;
  logic           last_pass;
  logic [VRW-1:0] vr;
  logic [VCW-1:0] vc;
  logic           drain_cnt;
  logic           s0_in;
  logic           scan_col_end;
  logic           scan_row_end;

  // Pipeline stages behind the scan.
  logic           p1_valid;
  logic [VRW-1:0] p1_vr;
  logic [VCW-1:0] p1_vc;
  logic           p1_in;
  logic           p2_valid;
  logic [VRW-1:0] p2_vr;
  logic [VCW-1:0] p2_vc;
  logic [4:0]     win [5];
  logic           cur;
  logic [3:0]     lbv;
  logic [4:0]     new_col;
  logic [16:0]    taps;
  logic           morph_bit;
  logic           emit;
  logic [VRW-1:0] emit_r;
  logic [VCW-1:0] emit_c;

  // Memories.
  logic           fr_we;
  logic [FAW-1:0] fr_waddr;
  logic           fr_wdata;
  logic           fr_rdata;
  logic [3:0]     lb_rdata;

  // Sums and division.
  logic [SW-1:0]  rsum;
  logic [SW-1:0]  csum;
  logic [NW-1:0]  lit_cnt;
  logic           div_start;
  logic [SW-1:0]  div_num;
  logic           div_done;
  logic [SW-1:0]  div_quot;
  logic [bbc_pkg::ROW_OUT_W-1:0] row_q;
  logic [bbc_pkg::COL_OUT_W-1:0] col_q;

  // Passes run erode, dilate, dilate, erode; out-of-frame taps read neutral.
  assign erode     = (pass == 2'd0) || (pass == 2'd3);
  assign last_pass = (pass == 2'd3);

  assign pop  = (state == B_LOAD) && !queue_empty;
  assign lrow = pop_item.first ? '0 : wrow;
  assign lcol = pop_item.first ? '0 : wcol;

  assign s0_in        = (32'(vr) < 32'(height_eff)) && (32'(vc) < 32'(width_eff));
  assign scan_col_end = (32'(vc) == 32'(width_eff) + 32'd1);
  assign scan_row_end = (32'(vr) == 32'(height_eff) + 32'd1);

  // New window column: current row from the frame, older rows from the line store.
  always_comb begin
    cur = p1_in ? fr_rdata : erode;
    for (int k = 0; k < 4; k++) begin
      lbv[k] = (32'(p1_vr) > k) ? lb_rdata[k] : erode;
    end
    new_col = {lbv, cur};
  end

  // Ellipse taps: full width on the middle three rows, center only on the outer two.
  always_comb begin
    taps = {win[0][3:1], win[1][3:1], win[2][4:0], win[3][3:1], win[4][3:1]};
    morph_bit = erode ? (&taps) : (|taps);
    emit   = p2_valid && (32'(p2_vr) >= 32'd2) && (32'(p2_vc) >= 32'd2);
    emit_r = p2_vr - VRW'(2);
    emit_c = p2_vc - VCW'(2);
  end

  // Frame store write: loading pixels, or the result of a pass written in place.
  always_comb begin
    if (state == B_LOAD) begin
      fr_we    = pop;
      fr_waddr = {lrow, lcol};
      fr_wdata = pop_item.lit;
    end else begin
      fr_we    = emit && !last_pass;
      fr_waddr = {emit_r[RW-1:0], emit_c[CW-1:0]};
      fr_wdata = morph_bit;
    end
  end

  assign div_start = (state == B_ROW_GO) || (state == B_COL_GO);
  assign div_num   = (state == B_ROW_GO) ? rsum : csum;

  bbc_ram #(
    .WIDTH (1),
    .DEPTH (FRAME_DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (fr_we),
    .waddr (fr_waddr),
    .wdata (fr_wdata),
    .raddr ({vr[RW-1:0], vc[CW-1:0]}),
    .rdata (fr_rdata)
  );

  bbc_ram #(
    .WIDTH (4),
    .DEPTH (LB_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (p1_valid),
    .waddr (p1_vc),
    .wdata (new_col[3:0]),
    .raddr (vc),
    .rdata (lb_rdata)
  );

  bbc_div #(
    .NUM_W (SW),
    .DEN_W (NW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (lit_cnt + NW'(1)),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Sequencer: load, four passes, two divisions, then hand off the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_LOAD;
      pass      <= '0;
      wrow      <= '0;
      wcol      <= '0;
      vr        <= '0;
      vc        <= '0;
      drain_cnt <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_LOAD: begin
          if (pop) begin
            if (pop_item.row_end) begin
              wcol <= '0;
              wrow <= lrow + RW'(1);
            end else begin
              wrow <= lrow;
              wcol <= lcol + CW'(1);
            end
            if (pop_item.frame_end) begin
              pass  <= '0;
              state <= B_PREP;
            end
          end
        end
        B_PREP: begin
          vr    <= '0;
          vc    <= '0;
          state <= B_SCAN;
        end
        B_SCAN: begin
          if (scan_col_end) begin
            vc <= '0;
            if (scan_row_end) begin
              drain_cnt <= 1'b0;
              state     <= B_DRAIN;
            end else begin
              vr <= vr + VRW'(1);
            end
          end else begin
            vc <= vc + VCW'(1);
          end
        end
        B_DRAIN: begin
          drain_cnt <= 1'b1;
          if (drain_cnt) begin
            if (last_pass) begin
              state <= B_ROW_GO;
            end else begin
              pass  <= pass + 2'd1;
              state <= B_PREP;
            end
          end
        end
        B_ROW_GO:  state <= B_ROW_DIV;
        B_ROW_DIV: begin
          if (div_done) begin
            row_q <= bbc_pkg::ROW_OUT_W'(div_quot);
            state <= B_COL_GO;
          end
        end
        B_COL_GO:  state <= B_COL_DIV;
        B_COL_DIV: begin
          if (div_done) begin
            col_q <= bbc_pkg::COL_OUT_W'(div_quot);
            state <= B_HOLD;
          end
        end
        B_HOLD: begin
          if (!out_valid) begin
            out_valid       <= 1'b1;
            row_centroid    <= row_q;
            column_centroid <= col_q;
            lit_pixel_count <= bbc_pkg::COUNT_OUT_W'(lit_cnt);
            state           <= B_LOAD;
          end
        end
        default: state <= B_LOAD;
      endcase
    end
  end

  // Stage valids.
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      p1_valid <= (state == B_SCAN);
      p2_valid <= p1_valid;
    end
  end

  // Stage payloads and the 5x5 window.
  always_ff @(posedge clk) begin
    p1_vr <= vr;
    p1_vc <= vc;
    p1_in <= s0_in;
    p2_vr <= p1_vr;
    p2_vc <= p1_vc;
    if (state == B_PREP) begin
      for (int k = 0; k < 5; k++) begin
        win[k] <= {5{erode}};
      end
    end else if (p1_valid) begin
      win[0] <= new_col;
      for (int k = 1; k < 5; k++) begin
        win[k] <= win[k-1];
      end
    end
  end

  // Centroid sums over the output of the last pass.
  always_ff @(posedge clk) begin
    if (state == B_PREP && last_pass) begin
      rsum    <= '0;
      csum    <= '0;
      lit_cnt <= '0;
    end else if (emit && last_pass && morph_bit) begin
      rsum    <= rsum + SW'(emit_r);
      csum    <= csum + SW'(emit_c);
      lit_cnt <= lit_cnt + NW'(1);
    end
  end

  // The window pipeline is empty whenever pixels are being loaded.
  a_pipe_empty_on_load: assert property (@(posedge clk) disable iff (rst)
    (state == B_LOAD) |-> (!p1_valid && !p2_valid))
    else $error("window pipeline busy while loading pixels");

  // A quotient only arrives while a division is awaited.
  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == B_ROW_DIV || state == B_COL_DIV))
    else $error("divider finished outside a division state");

  // Every emitted pass result lies inside the frame.
  a_emit_in_frame: assert property (@(posedge clk) disable iff (rst)
    emit |-> ((32'(emit_r) < 32'(height_eff)) && (32'(emit_c) < 32'(width_eff))))
    else $error("pass result outside the frame");

endmodule

`default_nettype wire

### design/bright_blob_centroid.sv
`default_nettype none

// Bright blob centroid. Grey pixels enter in raster order; each is lit when at or above
// threshold. At the last pixel of a frame the binary frame goes through erode, dilate,
// dilate, erode with a 5x5 ellipse, and one item gives row and column index sums divided
// by (lit count + 1), plus the lit count. Pixels are taken one per cycle while the frame
// loads. After the last pixel, input stalls once the four-entry queue fills: each pass
// scans the single-port-read frame store once, and the two divisions run on the shared
// bit-serial divider. The result sits in an output register while the next frame loads.
// Writing frame_width or frame_height drops a partial frame.
module bright_blob_centroid #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [bbc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [bbc_pkg::SIZE_W-1:0]          cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [bbc_pkg::PIXEL_W-1:0]         pixel,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [bbc_pkg::ROW_OUT_W-1:0]            row_centroid,
  output logic [bbc_pkg::COL_OUT_W-1:0]            column_centroid,
  output logic [bbc_pkg::COUNT_OUT_W-1:0]          lit_pixel_count
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [bbc_pkg::PIXEL_W-1:0] threshold;
  logic [bbc_pkg::SIZE_W-1:0]  frame_width;
  logic [bbc_pkg::SIZE_W-1:0]  frame_height;
  logic [WW-1:0]               width_eff;
  logic [HW-1:0]               height_eff;
  logic                        cfg_write;
  logic                        restart;
  logic                        push;
  bbc_pkg::pix_item_t          push_item;
  logic                        pop;
  bbc_pkg::pix_item_t          pop_item;
  logic                        queue_full;
  logic                        queue_empty;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign restart   = cfg_write &&
                     (cfg_index == bbc_pkg::REG_FRAME_WIDTH ||
                      cfg_index == bbc_pkg::REG_FRAME_HEIGHT);

  // Frame sizes limited to one and to the maximum the stores hold.
  always_comb begin
    if (frame_width == '0) begin
      width_eff = WW'(1);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(frame_width);
    end
    if (frame_height == '0) begin
      height_eff = HW'(1);
    end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
      height_eff = HW'(MAX_HEIGHT);
    end else begin
      height_eff = HW'(frame_height);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= bbc_pkg::THRESHOLD_RESET;
      frame_width  <= bbc_pkg::WIDTH_RESET;
      frame_height <= bbc_pkg::HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bbc_pkg::REG_THRESHOLD:    threshold    <= cfg_data[bbc_pkg::PIXEL_W-1:0];
        bbc_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        bbc_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  bbc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .restart    (restart),
    .threshold  (threshold),
    .width_eff  (width_eff),
    .height_eff (height_eff),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pixel      (pixel),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  bbc_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  bbc_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .width_eff       (width_eff),
    .height_eff      (height_eff),
    .queue_empty     (queue_empty),
    .pop             (pop),
    .pop_item        (pop_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .row_centroid    (row_centroid),
    .column_centroid (column_centroid),
    .lit_pixel_count (lit_pixel_count)
  );

endmodule

`default_nettype wire
